// File: hdl/bdq_pkg.sv
// Shared types and codes for the bounded deque with remove-by-value.
// Used by the controller, the datapath, the top level and the checker.
package bdq_pkg;

   localparam logic [1:0] OP_PREPEND = 2'd0;
   localparam logic [1:0] OP_APPEND  = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_FULL = 2'd1;
   localparam logic [1:0] STATUS_MISS = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] entry_count;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       take_fill;
      logic       read_free;
      logic       take_free;
      logic       ins_first;
      logic       ins_link;
      logic       walk_start;
      logic       walk_step;
      logic       unlink;
      logic       finish;
      logic [1:0] status;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       stack_empty;
      logic       match;
      logic       walk_last;
   } stat_type;

endpackage

// File: hdl/bdq_datapath.sv
// Datapath of the deque: value, link and free-slot memories, head, tail and counters.
// Depends on bdq_pkg; driven by bdq_controller through command and status structs.
module bdq_datapath #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  bdq_pkg::req_type req_data,
   input  bdq_pkg::cmd_type cmd,
   output bdq_pkg::stat_type stat,
   output bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
   localparam int EW = (CW > 5) ? CW : 5;

   logic [VALUE_WIDTH-1:0] value_mem [DEPTH];
   logic [AW-1:0]          next_mem  [DEPTH];
   logic [AW-1:0]          prev_mem  [DEPTH];
   logic [AW-1:0]          free_mem  [DEPTH];

   logic [1:0]             op_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [AW-1:0]          head_ff, tail_ff, slot_ff, free_rd_ff;
   logic [CW-1:0]          count_ff, fill_ff, sp_ff, seen_ff;
   logic [VALUE_WIDTH-1:0] val_rd_ff;
   logic [AW-1:0]          nxt_rd_ff, prv_rd_ff, rd_addr_ff;
   logic [1:0]             status_ff;
   rsp_type                rsp_ff;

   logic [XW-1:0]          value_ext;
   logic [EW-1:0]          count_ext;
   logic [CW-1:0]          sp_dec, seen_inc;
   logic [AW-1:0]          rd_addr_in;
   logic                   front, middle;
   logic                   next_we, prev_we;
   logic [AW-1:0]          next_wa, next_wd, prev_wa, prev_wd;

   assign value_ext  = XW'($unsigned(req_data.value));
   assign count_ext  = EW'(count_ff);
   assign sp_dec     = sp_ff - 1'b1;
   assign seen_inc   = seen_ff + 1'b1;
   assign front      = (op_ff == OP_PREPEND);
   assign middle     = (count_ff != CW'(1)) && (rd_addr_ff != head_ff) && (rd_addr_ff != tail_ff);
   assign rd_addr_in = cmd.walk_start ? head_ff : nxt_rd_ff;

   always_comb begin
      next_we = 1'b0;
      next_wa = slot_ff;
      next_wd = slot_ff;
      prev_we = 1'b0;
      prev_wa = slot_ff;
      prev_wd = slot_ff;
      if (cmd.ins_first) begin
         next_we = 1'b1;
         prev_we = 1'b1;
         if (count_ff != '0) begin
            if (front) begin
               next_wd = head_ff;
            end else begin
               prev_wd = tail_ff;
            end
         end
      end else if (cmd.ins_link) begin
         if (front) begin
            prev_we = 1'b1;
            prev_wa = head_ff;
         end else begin
            next_we = 1'b1;
            next_wa = tail_ff;
         end
      end else if (cmd.unlink && middle) begin
         next_we = 1'b1;
         next_wa = prv_rd_ff;
         next_wd = nxt_rd_ff;
         prev_we = 1'b1;
         prev_wa = nxt_rd_ff;
         prev_wd = prv_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_first) begin
         value_mem[slot_ff] <= value_ff;
      end
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (cmd.unlink) begin
         free_mem[sp_ff[AW-1:0]] <= rd_addr_ff;
      end
      if (cmd.read_free) begin
         free_rd_ff <= free_mem[sp_dec[AW-1:0]];
      end
      if (cmd.walk_start || cmd.walk_step) begin
         val_rd_ff  <= value_mem[rd_addr_in];
         nxt_rd_ff  <= next_mem[rd_addr_in];
         prv_rd_ff  <= prev_mem[rd_addr_in];
         rd_addr_ff <= rd_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_data.operation;
         value_ff <= value_ext[VALUE_WIDTH-1:0];
      end
      if (cmd.take_fill) begin
         slot_ff <= fill_ff[AW-1:0];
      end else if (cmd.take_free) begin
         slot_ff <= free_rd_ff;
      end
      if (cmd.walk_start) begin
         seen_ff <= '0;
      end else if (cmd.walk_step) begin
         seen_ff <= seen_inc;
      end
      if (cmd.finish) begin
         status_ff <= cmd.status;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status      <= status_ff;
         rsp_ff.entry_count <= count_ext[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fill_ff  <= '0;
         sp_ff    <= '0;
      end else begin
         if (cmd.take_fill) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (cmd.ins_first && (count_ff == '0)) begin
            head_ff  <= slot_ff;
            tail_ff  <= slot_ff;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.ins_link) begin
            if (front) begin
               head_ff <= slot_ff;
            end else begin
               tail_ff <= slot_ff;
            end
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.take_free) begin
            sp_ff <= sp_dec;
         end
         if (cmd.unlink) begin
            if (count_ff != CW'(1)) begin
               if (rd_addr_ff == head_ff) begin
                  head_ff <= nxt_rd_ff;
               end else if (rd_addr_ff == tail_ff) begin
                  tail_ff <= prv_rd_ff;
               end
            end
            sp_ff    <= sp_ff + 1'b1;
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign stat.op          = op_ff;
   assign stat.full        = (count_ff == CW'(DEPTH));
   assign stat.empty       = (count_ff == '0);
   assign stat.stack_empty = (sp_ff == '0);
   assign stat.match       = (val_rd_ff == value_ff);
   assign stat.walk_last   = (seen_inc == count_ff);
   assign rsp_data         = rsp_ff;

endmodule

// File: hdl/bdq_controller.sv
// Sequencing state machine of the deque: dispatch, insert, list walk and response.
// Depends on bdq_pkg; commands bdq_datapath and owns the result valid flag.
module bdq_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bdq_pkg::stat_type stat,
   output bdq_pkg::cmd_type  cmd
);
   import bdq_pkg::*;

   typedef enum logic [2:0] {
      IDLE, DISPATCH, ALLOC, INS_FIRST, INS_LINK, WALK, UNLINK, RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = DISPATCH;
            end
         end
         DISPATCH: begin
            priority if ((stat.op == OP_PREPEND) || (stat.op == OP_APPEND)) begin
               if (stat.full) begin
                  cmd.finish = 1'b1;
                  cmd.status = STATUS_FULL;
                  state_in   = RESPOND;
               end else if (stat.stack_empty) begin
                  cmd.take_fill = 1'b1;
                  state_in      = INS_FIRST;
               end else begin
                  cmd.read_free = 1'b1;
                  state_in      = ALLOC;
               end
            end else if (stat.op == OP_REMOVE) begin
               if (stat.empty) begin
                  cmd.finish = 1'b1;
                  cmd.status = STATUS_MISS;
                  state_in   = RESPOND;
               end else begin
                  cmd.walk_start = 1'b1;
                  state_in       = WALK;
               end
            end else begin
               cmd.finish = 1'b1;
               cmd.status = STATUS_DONE;
               state_in   = RESPOND;
            end
         end
         ALLOC: begin
            cmd.take_free = 1'b1;
            state_in      = INS_FIRST;
         end
         INS_FIRST: begin
            cmd.ins_first = 1'b1;
            if (stat.empty) begin
               cmd.finish = 1'b1;
               cmd.status = STATUS_DONE;
               state_in   = RESPOND;
            end else begin
               state_in = INS_LINK;
            end
         end
         INS_LINK: begin
            cmd.ins_link = 1'b1;
            cmd.finish   = 1'b1;
            cmd.status   = STATUS_DONE;
            state_in     = RESPOND;
         end
         WALK: begin
            if (stat.match) begin
               state_in = UNLINK;
            end else if (stat.walk_last) begin
               cmd.finish = 1'b1;
               cmd.status = STATUS_MISS;
               state_in   = RESPOND;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         UNLINK: begin
            cmd.unlink = 1'b1;
            cmd.finish = 1'b1;
            cmd.status = STATUS_DONE;
            state_in   = RESPOND;
         end
         RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/bounded_deque_remove_by_value_core.sv
// Top level of the bounded deque with remove-by-value.
// Depends on bdq_pkg, bdq_controller and bdq_datapath.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_ready   req_data   (operation, value)
//   rsp       out        rsp_valid/rsp_ready   rsp_data   (status, entry_count)
//
// A prepend or append fills a recycled or fresh slot and links it, or is dropped when full.
// A remove walks the linked list one entry per cycle through the registered link
// memory read, then unlinks the first match or reports a miss after the last entry.
// A new transaction is accepted while a finished result still waits in the output register.
// Reset is synchronous and empties the list; no clearing pass over the memories is needed.
module bounded_deque_remove_by_value_core #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bdq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bdq_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bdq_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// File: hdl/bdq_checker.sv
// Port-level checks for the bounded deque core, and the bind that attaches them.
// Depends on bdq_pkg and bounded_deque_remove_by_value_core.
module bdq_checker #(
   parameter int DEPTH = 16
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input bdq_pkg::rsp_type rsp_data
);
   import bdq_pkg::*;

   // A stalled result holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The core works on one transaction at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted while busy");

   // A dropped insert reports a full store.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |-> rsp_data.entry_count == 5'(DEPTH))
      else $error("full status with a count below the depth");

   // A reported count never exceeds the depth; depths above 31 are not checked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 31) || (rsp_data.entry_count <= 5'(DEPTH)))
      else $error("entry count above the depth");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind bounded_deque_remove_by_value_core bdq_checker #(
   .DEPTH (DEPTH)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
